/* sv/ehp_pkg.sv */
`timescale 1ns / 1ps
// Envelope header parser package: payload structs, queue entry, codes and constants.
// No dependencies.
package ehp_pkg;

	localparam int unsigned DEFAULT_QUEUE_DEPTH = 4;
	localparam int unsigned CFG_INDEX_W         = 1;
	localparam int unsigned CFG_DATA_W          = 64;

	localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC   = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_VERSION = 1'b1;

	localparam logic [63:0] MAGIC_RESET   = 64'h3130545059524353;
	localparam logic [7:0]  VERSION_RESET = 8'd1;

	// byte positions in the header
	localparam logic [9:0] POS_VERSION   = 10'd8;
	localparam logic [9:0] POS_SALT_LEN  = 10'd9;
	localparam logic [9:0] POS_NONCE_LEN = 10'd10;
	localparam logic [9:0] POS_TAG_LEN   = 10'd11;
	localparam logic [9:0] POS_PT_SIZE   = 10'd19;
	localparam logic [9:0] POS_CT_SIZE   = 10'd27;
	localparam logic [9:0] POS_COST_N    = 10'd35;
	localparam logic [9:0] POS_MAX_MEM   = 10'd43;
	localparam logic [9:0] POS_COST_R0   = 10'd44;
	localparam logic [9:0] POS_COST_R    = 10'd47;
	localparam logic [9:0] POS_COST_P    = 10'd51;
	localparam logic [9:0] FIXED_LEN     = 10'd52;

	localparam logic [3:0] KIND_VERSION   = 4'd0;
	localparam logic [3:0] KIND_SALT_LEN  = 4'd1;
	localparam logic [3:0] KIND_NONCE_LEN = 4'd2;
	localparam logic [3:0] KIND_TAG_LEN   = 4'd3;
	localparam logic [3:0] KIND_PT_SIZE   = 4'd4;
	localparam logic [3:0] KIND_CT_SIZE   = 4'd5;
	localparam logic [3:0] KIND_COST_N    = 4'd6;
	localparam logic [3:0] KIND_MAX_MEM   = 4'd7;
	localparam logic [3:0] KIND_COST_R    = 4'd8;
	localparam logic [3:0] KIND_COST_P    = 4'd9;
	localparam logic [3:0] KIND_SALT      = 4'd10;
	localparam logic [3:0] KIND_NONCE     = 4'd11;
	localparam logic [3:0] KIND_TAG       = 4'd12;
	localparam logic [3:0] KIND_END       = 4'd13;
	localparam logic [3:0] KIND_ERROR     = 4'd14;

	localparam logic [2:0] ERR_NONE        = 3'd0;
	localparam logic [2:0] ERR_TOO_SMALL   = 3'd1;
	localparam logic [2:0] ERR_BAD_MAGIC   = 3'd2;
	localparam logic [2:0] ERR_BAD_VERSION = 3'd3;
	localparam logic [2:0] ERR_TRUNCATED   = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic [3:0]  result_kind;
		logic [63:0] field_value;
		logic [7:0]  element_index;
		logic [2:0]  error_code;
		logic        last_result;
	} out_t;

	// one queued request: a result, optionally followed by the end result
	typedef struct packed {
		logic [3:0]  kind;
		logic [63:0] value;
		logic [7:0]  idx;
		logic [2:0]  err;
		logic        two;
		logic [9:0]  total;
	} qentry_t;

endpackage

/* sv/ehp_front.sv */
`timescale 1ns / 1ps
// Front part: config registers, byte-position tracking and result classification.
// Depends on ehp_pkg.
module ehp_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  ehp_pkg::in_t                       in_data,
	input  logic                               cfg_we,
	input  logic [ehp_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [ehp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                               queue_full,
	output logic                               push,
	output ehp_pkg::qentry_t                   push_entry
);

	logic [63:0] magic_q;
	logic [7:0]  version_q;
	logic [9:0]  pos_q;
	logic [63:0] acc_q;
	logic        mm_q, vm_q, fin_q;
	logic [7:0]  salt_q, nonce_q, tag_q;

	logic [9:0]  pos;
	logic        mm_n, vm_n, fin_n, live;
	logic [63:0] acc_n;
	logic [7:0]  salt_n, nonce_n, tag_n;
	logic [2:0]  sh;
	logic [9:0]  rel, rel_n, total;
	logic [9:0]  sn_sum;
	logic [3:0]  kind;
	logic [63:0] value;
	logic [7:0]  idx;
	logic        have;
	logic        accept;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		pos     = in_data.first_byte ? '0 : pos_q;
		live    = in_data.first_byte || !fin_q;
		mm_n    = in_data.first_byte ? 1'b0 : mm_q;
		vm_n    = in_data.first_byte ? 1'b0 : vm_q;
		salt_n  = in_data.first_byte ? '0 : salt_q;
		nonce_n = in_data.first_byte ? '0 : nonce_q;
		tag_n   = in_data.first_byte ? '0 : tag_q;
		acc_n   = acc_q;
		kind    = ehp_pkg::KIND_VERSION;
		value   = '0;
		idx     = '0;
		have    = 1'b0;
		sh      = '0;
		rel     = pos - ehp_pkg::FIXED_LEN;
		rel_n   = '0;
		sn_sum  = {2'b00, salt_n} + {2'b00, nonce_n};

		if (pos < ehp_pkg::POS_VERSION) begin
			if (in_data.data_byte != magic_q[{pos[2:0], 3'b000} +: 8])
				mm_n = 1'b1;
		end else if (pos == ehp_pkg::POS_VERSION) begin
			if (in_data.data_byte != version_q)
				vm_n = 1'b1;
			kind  = ehp_pkg::KIND_VERSION;
			value = {56'b0, in_data.data_byte};
			have  = 1'b1;
		end else if (pos <= ehp_pkg::POS_TAG_LEN) begin
			value = {56'b0, in_data.data_byte};
			have  = 1'b1;
			if (pos == ehp_pkg::POS_SALT_LEN) begin
				salt_n = in_data.data_byte;
				kind   = ehp_pkg::KIND_SALT_LEN;
			end else if (pos == ehp_pkg::POS_NONCE_LEN) begin
				nonce_n = in_data.data_byte;
				kind    = ehp_pkg::KIND_NONCE_LEN;
			end else begin
				tag_n = in_data.data_byte;
				kind  = ehp_pkg::KIND_TAG_LEN;
			end
		end else if (pos < ehp_pkg::FIXED_LEN) begin
			if (pos < ehp_pkg::POS_COST_R0)
				sh = pos[2:0] + 3'd4;
			else
				sh = {1'b0, pos[1:0]};
			if (sh == 3'd0)
				acc_n = {56'b0, in_data.data_byte};
			else
				acc_n = acc_q | ({56'b0, in_data.data_byte} << {sh, 3'b000});
			value = acc_n;
			case (pos)
				ehp_pkg::POS_PT_SIZE: begin kind = ehp_pkg::KIND_PT_SIZE; have = 1'b1; end
				ehp_pkg::POS_CT_SIZE: begin kind = ehp_pkg::KIND_CT_SIZE; have = 1'b1; end
				ehp_pkg::POS_COST_N:  begin kind = ehp_pkg::KIND_COST_N;  have = 1'b1; end
				ehp_pkg::POS_MAX_MEM: begin kind = ehp_pkg::KIND_MAX_MEM; have = 1'b1; end
				ehp_pkg::POS_COST_R:  begin kind = ehp_pkg::KIND_COST_R;  have = 1'b1; end
				ehp_pkg::POS_COST_P:  begin kind = ehp_pkg::KIND_COST_P;  have = 1'b1; end
				default: have = 1'b0;
			endcase
		end else begin
			if (rel < {2'b00, salt_n}) begin
				kind  = ehp_pkg::KIND_SALT;
				rel_n = rel;
			end else if (rel < sn_sum) begin
				kind  = ehp_pkg::KIND_NONCE;
				rel_n = rel - {2'b00, salt_n};
			end else begin
				kind  = ehp_pkg::KIND_TAG;
				rel_n = rel - sn_sum;
			end
			idx   = rel_n[7:0];
			value = {56'b0, in_data.data_byte};
			have  = 1'b1;
		end

		total = ehp_pkg::FIXED_LEN + sn_sum + {2'b00, tag_n};

		push_entry       = '0;
		push_entry.total = total;
		push             = 1'b0;
		fin_n            = 1'b0;
		if (pos < ehp_pkg::POS_COST_P && in_data.last_byte) begin
			push_entry.kind = ehp_pkg::KIND_ERROR;
			push_entry.err  = ehp_pkg::ERR_TOO_SMALL;
			push            = 1'b1;
			fin_n           = 1'b1;
		end else if (pos == ehp_pkg::POS_COST_P && mm_n) begin
			push_entry.kind = ehp_pkg::KIND_ERROR;
			push_entry.err  = ehp_pkg::ERR_BAD_MAGIC;
			push            = 1'b1;
			fin_n           = 1'b1;
		end else if (pos == ehp_pkg::POS_COST_P && vm_n) begin
			push_entry.kind = ehp_pkg::KIND_ERROR;
			push_entry.err  = ehp_pkg::ERR_BAD_VERSION;
			push            = 1'b1;
			fin_n           = 1'b1;
		end else if (pos >= ehp_pkg::POS_COST_P
			&& ({1'b0, pos} + 11'd1) >= {1'b0, total}) begin
			push_entry.kind  = kind;
			push_entry.value = value;
			push_entry.idx   = idx;
			push_entry.two   = 1'b1;
			push             = 1'b1;
			fin_n            = 1'b1;
		end else if (pos >= ehp_pkg::POS_COST_P && in_data.last_byte) begin
			push_entry.kind = ehp_pkg::KIND_ERROR;
			push_entry.err  = ehp_pkg::ERR_TRUNCATED;
			push            = 1'b1;
			fin_n           = 1'b1;
		end else if (have && !mm_n && !vm_n) begin
			push_entry.kind  = kind;
			push_entry.value = value;
			push_entry.idx   = idx;
			push             = 1'b1;
		end
		push = push && accept && live;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q   <= ehp_pkg::MAGIC_RESET;
			version_q <= ehp_pkg::VERSION_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ehp_pkg::CFG_MAGIC:   magic_q   <= cfg_wdata;
				ehp_pkg::CFG_VERSION: version_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			acc_q   <= '0;
			mm_q    <= 1'b0;
			vm_q    <= 1'b0;
			fin_q   <= 1'b0;
			salt_q  <= '0;
			nonce_q <= '0;
			tag_q   <= '0;
		end else if (accept && live) begin
			acc_q   <= acc_n;
			mm_q    <= mm_n;
			vm_q    <= vm_n;
			fin_q   <= fin_n;
			salt_q  <= salt_n;
			nonce_q <= nonce_n;
			tag_q   <= tag_n;
			if (!fin_n)
				pos_q <= pos + 10'd1;
			else
				pos_q <= pos;
		end
	end

endmodule

/* sv/ehp_back.sv */
`timescale 1ns / 1ps
// Back part: request queue and result sequencing onto the output channel.
// Depends on ehp_pkg.
module ehp_back #(
	parameter int unsigned QueueDepth = ehp_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ehp_pkg::qentry_t  push_entry,
	output logic              queue_full,
	output logic              out_valid,
	input  logic              out_ready,
	output ehp_pkg::out_t     out_data
);

	localparam int unsigned PtrW = $clog2(QueueDepth);
	localparam int unsigned CntW = $clog2(QueueDepth + 1);

	ehp_pkg::qentry_t  mem_q [QueueDepth];
	logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]   count_q;
	logic              phase_q;
	ehp_pkg::qentry_t  head;
	logic              pop, take;

	assign head       = mem_q[rd_ptr_q];
	assign out_valid  = count_q != '0;
	assign queue_full = count_q == CntW'(QueueDepth);
	assign take       = out_valid && out_ready;
	assign pop        = take && (phase_q || !head.two);

	always_comb begin
		out_data = '0;
		if (phase_q) begin
			out_data.result_kind = ehp_pkg::KIND_END;
			out_data.field_value = {54'b0, head.total};
			out_data.last_result = 1'b1;
		end else begin
			out_data.result_kind   = head.kind;
			out_data.field_value   = head.value;
			out_data.element_index = head.idx;
			out_data.error_code    = head.err;
			out_data.last_result   = !head.two;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			phase_q  <= 1'b0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			if (push && !pop)
				count_q <= count_q + CntW'(1);
			else if (pop && !push)
				count_q <= count_q - CntW'(1);
			if (take)
				phase_q <= !pop;
		end
	end

endmodule

/* sv/envelope_header_parser_unit.sv */
`timescale 1ns / 1ps
// Envelope header parser top level: front classifier feeding the result queue.
// Depends on ehp_pkg, ehp_front, ehp_back.
//
// Usage:
//   in channel (in_valid/in_ready/in_data): one header byte per request, with
//   first_byte restarting the parse and last_byte marking the end of data.
//   out channel (out_valid/out_ready/out_data): version, lengths, size and
//   cost fields, salt/nonce/tag bytes with their index, then an end result
//   carrying the ciphertext offset, or a single error result.
//   cfg port (cfg_we/cfg_index/cfg_wdata): magic word and expected version,
//   written while the block is idle.
// Throughput: one byte accepted per cycle while the queue is not full. The byte that completes a header
//   yields two results, the field and then the end result; all other bytes
//   yield at most one. Rate is set by the combinational classifier in the front.
// Output: each result is written into the queue when its byte is accepted and is presented from the queue head.
// Reset: config returns to "SCRYPT01" and version 1, the parse restarts at
//   byte 0 and the queue empties.
// Stall: a stalled receiver fills the QueueDepth-entry queue; in_ready then
//   drops until an entry is drained.
module envelope_header_parser_unit #(
	parameter int unsigned QueueDepth = ehp_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  ehp_pkg::in_t                    in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output ehp_pkg::out_t                   out_data,
	input  logic                            cfg_we,
	input  logic [ehp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ehp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	logic             push;
	logic             queue_full;
	ehp_pkg::qentry_t push_entry;

	ehp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.queue_full (queue_full),
		.push       (push),
		.push_entry (push_entry)
	);

	ehp_back #(
		.QueueDepth (QueueDepth)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.queue_full (queue_full),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule
